// ===== rtl/pcnw_pkg.sv =====
// pcnw_pkg: shared types and constants of the periodic cell neighbour walk unit
// used by pcnw_front, pcnw_back and the top level, no dependencies of its own

package pcnw_pkg;

  localparam int unsigned CoordW = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned IndexW = 24;
  localparam int unsigned YTermW = 16;
  localparam int unsigned AreaW  = 17;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [CountW-1:0] MinCount = 9'd3;
  localparam logic [CountW-1:0] MaxCount = 9'd256;

  localparam logic OpNeighbours = 1'b0;
  localparam logic OpCrossing   = 1'b1;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  localparam logic [1:0] RegCountX = 2'd0;
  localparam logic [1:0] RegCountY = 2'd1;
  localparam logic [1:0] RegCountZ = 2'd2;

  typedef enum logic [1:0] {
    KIND_NEIGHBOUR = 2'd0,
    KIND_ENTERED   = 2'd1,
    KIND_BAD       = 2'd2
  } kind_e;

  typedef struct packed {
    logic [CountW-1:0] count_x;
    logic [CountW-1:0] count_y;
    logic [CountW-1:0] count_z;
  } cfg_t;

  typedef struct packed {
    logic              opcode;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [CoordW-1:0] cell_z;
    logic [1:0]        cross_axis;
    logic              cross_positive;
  } item_t;

  // index terms per axis: slot 0 coordinate -1, 1 centre, 2 +1; crossed axis two out
  typedef struct packed {
    logic                   bad;
    logic                   opcode;
    logic [1:0]             axis;
    logic [2:0][CoordW-1:0] x_term;
    logic [2:0][YTermW-1:0] y_term;
    logic [2:0][IndexW-1:0] z_term;
    logic [IndexW-1:0]      ent_term;
  } desc_t;

  typedef struct packed {
    logic [IndexW-1:0] cell_index;
    kind_e             kind;
    logic              last;
  } res_t;

endpackage

// ===== rtl/pcnw_fifo.sv =====
// pcnw_fifo: small first-in first-out queue of flip-flops with registered count
// generic width and depth, no package dependency

module pcnw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule

// ===== rtl/pcnw_front.sv =====
// pcnw_front: accepts items, checks coordinates, wraps them and forms index terms
// depends on pcnw_pkg; two stages, second one holds the multipliers

module pcnw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pcnw_pkg::cfg_t  cfg_i,
  input  logic            push_i,
  output logic            full_o,
  input  pcnw_pkg::item_t item_i,
  output logic            desc_valid_o,
  output pcnw_pkg::desc_t desc_o,
  input  logic            desc_ready_i
);

  function automatic logic [pcnw_pkg::CountW-1:0] clamp_count(
    input logic [pcnw_pkg::CountW-1:0] v
  );
    logic [pcnw_pkg::CountW-1:0] r;
    r = v;
    if (v < pcnw_pkg::MinCount) begin
      r = pcnw_pkg::MinCount;
    end else if (v > pcnw_pkg::MaxCount) begin
      r = pcnw_pkg::MaxCount;
    end
    return r;
  endfunction

  logic [2:0][pcnw_pkg::CountW-1:0] n;
  logic [2:0][pcnw_pkg::CoordW-1:0] c;
  logic [2:0][pcnw_pkg::CoordW-1:0] dec1, inc1, dec2, inc2;
  logic [2:0][2:0][pcnw_pkg::CoordW-1:0] trip_d;
  logic [pcnw_pkg::CoordW-1:0] ent_d;
  logic bad_d;

  // stage a
  logic va_q;
  logic a_bad_q, a_op_q;
  logic [1:0] a_axis_q;
  logic [2:0][2:0][pcnw_pkg::CoordW-1:0] a_trip_q;
  logic [pcnw_pkg::CoordW-1:0] a_ent_q;

  // stage b
  logic vb_q;
  pcnw_pkg::desc_t desc_q, desc_d;
  logic [pcnw_pkg::AreaW-1:0] nxy_q, nxy_d;
  logic [17:0] nxy_full;

  logic ready_a, ready_b, accept;

  assign n[0] = clamp_count(cfg_i.count_x);
  assign n[1] = clamp_count(cfg_i.count_y);
  assign n[2] = clamp_count(cfg_i.count_z);
  assign c[0] = item_i.cell_x;
  assign c[1] = item_i.cell_y;
  assign c[2] = item_i.cell_z;

  assign ready_b = !vb_q || desc_ready_i;
  assign ready_a = !va_q || ready_b;
  assign full_o  = !ready_a;
  assign accept  = push_i && ready_a;

  // one and two step moves, each a single compare and subtract as n is at least three
  always_comb begin
    logic [pcnw_pkg::CountW-1:0] s1, s2, d2;
    for (int a = 0; a < 3; a++) begin
      s1 = {1'b0, c[a]} + 9'd1;
      s2 = {1'b0, c[a]} + 9'd2;
      d2 = {1'b0, c[a]} + n[a] - 9'd2;
      dec1[a] = (c[a] == '0) ? 8'(n[a] - 9'd1) : c[a] - 8'd1;
      inc1[a] = (s1 == n[a]) ? '0 : s1[7:0];
      inc2[a] = (s2 >= n[a]) ? 8'(s2 - n[a]) : s2[7:0];
      dec2[a] = (c[a] >= 8'd2) ? c[a] - 8'd2 : d2[7:0];
    end
  end

  always_comb begin
    logic [1:0] ax;
    ax = item_i.cross_axis;
    ent_d = '0;
    for (int a = 0; a < 3; a++) begin
      if (item_i.opcode == pcnw_pkg::OpCrossing && ax == 2'(a)) begin
        // crossed axis sits two steps out for the whole face
        trip_d[a][0] = item_i.cross_positive ? inc2[a] : dec2[a];
        trip_d[a][1] = item_i.cross_positive ? inc2[a] : dec2[a];
        trip_d[a][2] = item_i.cross_positive ? inc2[a] : dec2[a];
        ent_d        = item_i.cross_positive ? inc1[a] : dec1[a];
      end else begin
        trip_d[a][0] = dec1[a];
        trip_d[a][1] = c[a];
        trip_d[a][2] = inc1[a];
      end
    end
    bad_d = ({1'b0, c[0]} >= n[0]) || ({1'b0, c[1]} >= n[1]) || ({1'b0, c[2]} >= n[2]) ||
            (item_i.opcode == pcnw_pkg::OpCrossing && ax != pcnw_pkg::AxisX &&
             ax != pcnw_pkg::AxisY && ax != pcnw_pkg::AxisZ);
  end

  assign nxy_full = n[0] * n[1];
  assign nxy_d    = nxy_full[pcnw_pkg::AreaW-1:0];

  always_comb begin
    logic [16:0] yp;
    logic [24:0] zp, ep;
    logic [pcnw_pkg::AreaW-1:0] weight;
    desc_d.bad    = a_bad_q;
    desc_d.opcode = a_op_q;
    desc_d.axis   = a_axis_q;
    for (int k = 0; k < 3; k++) begin
      yp = a_trip_q[1][k] * n[0];
      zp = a_trip_q[2][k] * nxy_q;
      desc_d.x_term[k] = a_trip_q[0][k];
      desc_d.y_term[k] = yp[pcnw_pkg::YTermW-1:0];
      desc_d.z_term[k] = zp[pcnw_pkg::IndexW-1:0];
    end
    case (a_axis_q)
      pcnw_pkg::AxisX: weight = 17'd1;
      pcnw_pkg::AxisY: weight = {8'd0, n[0]};
      pcnw_pkg::AxisZ: weight = nxy_q;
      default:         weight = '0;
    endcase
    ep = a_ent_q * weight;
    desc_d.ent_term = ep[pcnw_pkg::IndexW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      nxy_q <= '0;
    end else begin
      nxy_q <= nxy_d;
      if (ready_a) begin
        va_q <= accept;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_bad_q  <= bad_d;
      a_op_q   <= item_i.opcode;
      a_axis_q <= item_i.cross_axis;
      a_trip_q <= trip_d;
      a_ent_q  <= ent_d;
    end
    if (ready_b && va_q) begin
      desc_q <= desc_d;
    end
  end

  assign desc_valid_o = vb_q;
  assign desc_o       = desc_q;

endmodule

// ===== rtl/pcnw_back.sv =====
// pcnw_back: walks one queued descriptor and emits one cell index a
// cycle while the result queue has room; depends on pcnw_pkg

module pcnw_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            desc_valid_i,
  input  pcnw_pkg::desc_t desc_i,
  output logic            desc_pop_o,
  output logic            res_push_o,
  output pcnw_pkg::res_t  res_o,
  input  logic            res_full_i
);

  logic [1:0] k0_q, k0_d, k1_q, k1_d, k2_q, k2_d;
  logic       ent_done_q, ent_done_d;
  logic [1:0] sel_x, sel_y, sel_z;
  logic       entering, is_last, emit;
  logic [pcnw_pkg::IndexW-1:0] tx, ty, tz, sum;
  pcnw_pkg::kind_e kind;

  assign emit = desc_valid_i && !res_full_i;

  always_comb begin
    sel_x    = 2'd1;
    sel_y    = 2'd1;
    sel_z    = 2'd1;
    entering = 1'b0;
    kind     = pcnw_pkg::KIND_NEIGHBOUR;
    is_last  = 1'b0;
    if (desc_i.bad) begin
      kind    = pcnw_pkg::KIND_BAD;
      is_last = 1'b1;
    end else if (desc_i.opcode == pcnw_pkg::OpNeighbours) begin
      sel_x   = k0_q;
      sel_y   = k1_q;
      sel_z   = k2_q;
      is_last = (k0_q == 2'd2) && (k1_q == 2'd2) && (k2_q == 2'd2);
    end else if (!ent_done_q) begin
      entering = 1'b1;
      kind     = pcnw_pkg::KIND_ENTERED;
    end else begin
      // face walk: outer loop on axis plus two, inner on axis plus one
      case (desc_i.axis)
        pcnw_pkg::AxisX: begin
          sel_z = k1_q;
          sel_y = k0_q;
        end
        pcnw_pkg::AxisY: begin
          sel_x = k1_q;
          sel_z = k0_q;
        end
        default: begin
          sel_y = k1_q;
          sel_x = k0_q;
        end
      endcase
      is_last = (k0_q == 2'd2) && (k1_q == 2'd2);
    end
  end

  always_comb begin
    tx = {16'd0, desc_i.x_term[sel_x]};
    ty = {8'd0, desc_i.y_term[sel_y]};
    tz = desc_i.z_term[sel_z];
    if (entering) begin
      case (desc_i.axis)
        pcnw_pkg::AxisX: tx = desc_i.ent_term;
        pcnw_pkg::AxisY: ty = desc_i.ent_term;
        default:         tz = desc_i.ent_term;
      endcase
    end
    sum = desc_i.bad ? '0 : tx + ty + tz;
  end

  always_comb begin
    k0_d       = k0_q;
    k1_d       = k1_q;
    k2_d       = k2_q;
    ent_done_d = ent_done_q;
    if (emit) begin
      if (is_last) begin
        k0_d       = '0;
        k1_d       = '0;
        k2_d       = '0;
        ent_done_d = 1'b0;
      end else if (entering) begin
        ent_done_d = 1'b1;
      end else if (k0_q == 2'd2) begin
        k0_d = '0;
        if (k1_q == 2'd2) begin
          k1_d = '0;
          k2_d = k2_q + 2'd1;
        end else begin
          k1_d = k1_q + 2'd1;
        end
      end else begin
        k0_d = k0_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k0_q       <= '0;
      k1_q       <= '0;
      k2_q       <= '0;
      ent_done_q <= 1'b0;
    end else begin
      k0_q       <= k0_d;
      k1_q       <= k1_d;
      k2_q       <= k2_d;
      ent_done_q <= ent_done_d;
    end
  end

  assign res_push_o       = emit;
  assign desc_pop_o       = emit && is_last;
  assign res_o.cell_index = sum;
  assign res_o.kind       = kind;
  assign res_o.last       = is_last;

  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.kind == pcnw_pkg::KIND_BAD |-> res_o.last && desc_pop_o)
    else $error("bad coordinate word not a single closing word");

  a_pop_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_pop_o |=> k0_q == '0 && k1_q == '0 && k2_q == '0 && !ent_done_q)
    else $error("walk counters not rewound after descriptor retired");

  a_entered_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.kind == pcnw_pkg::KIND_ENTERED |=>
      ent_done_q && k0_q == '0 && k1_q == '0)
    else $error("face walk did not start at its origin after entered cell");

endmodule

// ===== rtl/periodic_cell_neighbour_walk_unit.sv =====
// periodic_cell_neighbour_walk_unit: top level, configuration registers and queues
// depends on pcnw_pkg, pcnw_front, pcnw_fifo and pcnw_back
//
// Usage: program count_x, count_y, count_z (byte addresses 0, 4, 8) over the
// register port while no item is in flight; each resets to 3 and is clamped
// to 3..256 when used. Items enter through push/full: an item is taken on a
// clock edge with push high and full low. Results leave through empty/pop:
// the oldest result sits on cell_index_o, kind_o, last_o while empty is low
// and is taken on an edge with pop high.
// A neighbourhood item gives 27 results, a face crossing item gives 10 (the
// entered cell first), an item with a bad coordinate or axis gives one. The
// back end produces one result per cycle from a single three-way adder while
// the result queue has room, finishing an item before it takes the next; the
// front end takes a new item every cycle until the descriptor queue fills.
// If the receiver stops popping, the result queue fills, the back end holds,
// then the descriptor queue and front end fill and full rises; nothing is
// dropped. Reset empties all queues and the walk counters and returns the
// counts to 3.

module periodic_cell_neighbour_walk_unit #(
  parameter int unsigned DESC_DEPTH = 2,
  parameter int unsigned RES_DEPTH  = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcnw_pkg::AddrW-1:0]    paddr,
  input  logic [pcnw_pkg::DataW-1:0]    pwdata,
  output logic [pcnw_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  // items
  input  logic                          push,
  output logic                          full,
  input  logic                          opcode_i,
  input  logic [pcnw_pkg::CoordW-1:0]   cell_x_i,
  input  logic [pcnw_pkg::CoordW-1:0]   cell_y_i,
  input  logic [pcnw_pkg::CoordW-1:0]   cell_z_i,
  input  logic [1:0]                    cross_axis_i,
  input  logic                          cross_positive_i,
  // results
  output logic                          empty,
  input  logic                          pop,
  output logic [pcnw_pkg::IndexW-1:0]   cell_index_o,
  output logic [1:0]                    kind_o,
  output logic                          last_o
);

  pcnw_pkg::cfg_t  cfg_q, cfg_d;
  pcnw_pkg::item_t item;
  pcnw_pkg::desc_t front_desc, back_desc;
  pcnw_pkg::res_t  back_res, out_res;
  logic cfg_wr;
  logic front_desc_valid, desc_full, desc_empty, desc_pop;
  logic res_push, res_full;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        pcnw_pkg::RegCountX: cfg_d.count_x = pwdata[pcnw_pkg::CountW-1:0];
        pcnw_pkg::RegCountY: cfg_d.count_y = pwdata[pcnw_pkg::CountW-1:0];
        pcnw_pkg::RegCountZ: cfg_d.count_z = pwdata[pcnw_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pcnw_pkg::RegCountX: prdata = {23'd0, cfg_q.count_x};
      pcnw_pkg::RegCountY: prdata = {23'd0, cfg_q.count_y};
      pcnw_pkg::RegCountZ: prdata = {23'd0, cfg_q.count_z};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count_x <= pcnw_pkg::MinCount;
      cfg_q.count_y <= pcnw_pkg::MinCount;
      cfg_q.count_z <= pcnw_pkg::MinCount;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign item.opcode         = opcode_i;
  assign item.cell_x         = cell_x_i;
  assign item.cell_y         = cell_y_i;
  assign item.cell_z         = cell_z_i;
  assign item.cross_axis     = cross_axis_i;
  assign item.cross_positive = cross_positive_i;

  pcnw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .full_o       (full),
    .item_i       (item),
    .desc_valid_o (front_desc_valid),
    .desc_o       (front_desc),
    .desc_ready_i (!desc_full)
  );

  pcnw_fifo #(
    .WIDTH ($bits(pcnw_pkg::desc_t)),
    .DEPTH (DESC_DEPTH)
  ) u_desc_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_desc_valid),
    .full_o  (desc_full),
    .wdata_i (front_desc),
    .pop_i   (desc_pop),
    .empty_o (desc_empty),
    .rdata_o (back_desc)
  );

  pcnw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (!desc_empty),
    .desc_i       (back_desc),
    .desc_pop_o   (desc_pop),
    .res_push_o   (res_push),
    .res_o        (back_res),
    .res_full_i   (res_full)
  );

  pcnw_fifo #(
    .WIDTH ($bits(pcnw_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (back_res),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (out_res)
  );

  assign cell_index_o = out_res.cell_index;
  assign kind_o       = out_res.kind;
  assign last_o       = out_res.last;

endmodule
